// ===== rtl/sorted_array_priority_queue_top_macros.svh =====
// Assertion macros for the sorted-array priority queue checker.
// Used by sapq_checker.sv; expects clk_i and rst_ni in scope.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_TOP_MACROS_SVH

// Same-cycle implication.
`define SAPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sapq assertion failed");

// Next-cycle implication.
`define SAPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sapq assertion failed");

`endif

// ===== rtl/sapq_pkg.sv =====
// Shared types and constants for the sorted-array priority queue.
// No dependencies.
`default_nettype none

package sapq_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned TagW = 8;
  localparam int unsigned CntOutW = 6;

  localparam logic signed [KeyW-1:0] EmptyKey = 32'sh0000_ffff;
  localparam logic [TagW-1:0] EmptyTag = 8'h78;
  localparam logic [CntOutW-1:0] CapReset = 6'd32;

  typedef enum logic [1:0] {
    MODE_ENQ = 2'd0,
    MODE_DEQ = 2'd1,
    MODE_CLR = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [TagW-1:0]        tag;
  } entry_t;

  // Broadcast to every cell.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sapq_cell.sv =====
// One slot of the sorted chain: holds one entry, compares it with the new key
// and keeps its own, the new, the left or the right entry. Uses sapq_pkg.
`default_nettype none

module sapq_cell (
  input  wire logic            clk_i,
  input  wire sapq_pkg::cmd_t  cmd_i,
  input  wire logic            occ_i,
  input  wire logic            left_ins_i,
  input  wire sapq_pkg::entry_t left_entry_i,
  input  wire sapq_pkg::entry_t right_entry_i,
  output logic                 ins_o,
  output sapq_pkg::entry_t     entry_o
);

  sapq_pkg::entry_t entry_q, entry_d;

  // New entry belongs here or further left: slot empty or holds a smaller key.
  assign ins_o = !occ_i || (entry_q.key < cmd_i.ent.key);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.enq) begin
      if (left_ins_i) begin
        entry_d = left_entry_i;
      end else if (ins_o) begin
        entry_d = cmd_i.ent;
      end
    end else if (cmd_i.deq) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_array_priority_queue_top.sv =====
// Sorted-array max-priority queue: chain of sapq_cell slots plus count and
// result registers. Uses sapq_pkg and sapq_cell.
//
// Usage:
//   Command channel: drive mode_i/key_i/tag_i with start high; the transaction
//   is taken at a clock edge where start is high and busy is low. busy stays
//   low, so one operation can be taken every cycle.
//   Result: in the cycle after the transaction, result_valid_o is high for one
//   cycle with status_o, out_key_o, out_tag_o and the head and count after
//   the operation. The receiver cannot stall; a result is shown once.
//   Throughput 1 operation per cycle. Every slot compares
//   its key with the incoming key in parallel and shifts by one toward its
//   neighbor, so the slot chain sets the cycle time (one 32-bit compare and
//   a 4:1 select per slot).
//   Config channel: cfg_data_i written to the capacity limit on
//   cfg_valid_i && cfg_ready_o; write only while no operation is in flight.
//   Reset: queue empty, capacity limit 32, no result pending.
`default_nettype none

module sorted_array_priority_queue_top #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      mode_i,
  input  wire logic signed [sapq_pkg::KeyW-1:0] key_i,
  input  wire logic [sapq_pkg::TagW-1:0]       tag_i,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [sapq_pkg::CntOutW-1:0]    cfg_data_i,
  output logic                                 result_valid_o,
  output logic [1:0]                           status_o,
  output logic signed [sapq_pkg::KeyW-1:0]     out_key_o,
  output logic [sapq_pkg::TagW-1:0]            out_tag_o,
  output logic                                 head_valid_o,
  output logic signed [sapq_pkg::KeyW-1:0]     head_key_o,
  output logic [sapq_pkg::TagW-1:0]            head_tag_o,
  output logic [sapq_pkg::CntOutW-1:0]         count_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > sapq_pkg::CntOutW) ? CntW : sapq_pkg::CntOutW;

  logic [CntW-1:0] count_q, count_d;
  logic [sapq_pkg::CntOutW-1:0] cap_q;
  logic rvalid_q;
  sapq_pkg::status_e status_q, status_d;
  sapq_pkg::entry_t  out_q, out_d;

  logic [CmpW-1:0] count_w, cap_w, depth_w, eff_cap;
  logic accept, full, empty;
  sapq_pkg::cmd_t cmd;

  logic [DEPTH-1:0]        occ;
  logic [DEPTH-1:0]        ins;
  sapq_pkg::entry_t        ent [DEPTH];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  assign count_w = CmpW'(count_q);
  assign cap_w   = CmpW'(cap_q);
  assign depth_w = CmpW'(DEPTH);
  assign eff_cap = (cap_w < depth_w) ? cap_w : depth_w;
  assign full    = count_w >= eff_cap;
  assign empty   = (count_q == '0);

  always_comb begin
    cmd.enq     = 1'b0;
    cmd.deq     = 1'b0;
    cmd.ent.key = key_i;
    cmd.ent.tag = tag_i;
    count_d     = count_q;
    status_d    = sapq_pkg::ST_OK;
    out_d.key   = '0;
    out_d.tag   = '0;
    if (accept) begin
      case (sapq_pkg::mode_e'(mode_i))
        sapq_pkg::MODE_ENQ: begin
          if (full) begin
            status_d = sapq_pkg::ST_FULL;
          end else begin
            cmd.enq = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        sapq_pkg::MODE_DEQ: begin
          if (empty) begin
            status_d  = sapq_pkg::ST_EMPTY;
            out_d.key = sapq_pkg::EmptyKey;
            out_d.tag = sapq_pkg::EmptyTag;
          end else begin
            cmd.deq = 1'b1;
            out_d   = ent[0];
            count_d = count_q - 1'b1;
          end
        end
        sapq_pkg::MODE_CLR: begin
          count_d = '0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cap_q    <= sapq_pkg::CapReset;
      rvalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      rvalid_q <= accept;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      out_q    <= out_d;
    end
  end

  // Slot chain; slot 0 holds the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             left_ins;
    sapq_pkg::entry_t left_ent, right_ent;

    assign occ[i] = count_q > CntW'(i);

    if (i == 0) begin : g_first
      assign left_ins = 1'b0;
      assign left_ent = cmd.ent;
    end else begin : g_mid
      assign left_ins = ins[i-1];
      assign left_ent = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = ent[i];
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    sapq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occ_i         (occ[i]),
      .left_ins_i    (left_ins),
      .left_entry_i  (left_ent),
      .right_entry_i (right_ent),
      .ins_o         (ins[i]),
      .entry_o       (ent[i])
    );
  end

  assign result_valid_o = rvalid_q;
  assign status_o       = status_q;
  assign out_key_o      = out_q.key;
  assign out_tag_o      = out_q.tag;
  assign head_valid_o   = !empty;
  assign head_key_o     = empty ? sapq_pkg::EmptyKey : ent[0].key;
  assign head_tag_o     = empty ? sapq_pkg::EmptyTag : ent[0].tag;
  assign count_o        = count_w[sapq_pkg::CntOutW-1:0];

endmodule

`default_nettype wire

// ===== rtl/sapq_checker.sv =====
// Port-level checks for the sorted-array priority queue, bound to the top.
// Uses sorted_array_priority_queue_top_macros.svh and sapq_pkg.
`default_nettype none

`include "sorted_array_priority_queue_top_macros.svh"

module sapq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        result_valid_o,
  input wire logic [1:0]  status_o,
  input wire logic signed [31:0] out_key_o,
  input wire logic [7:0]  out_tag_o,
  input wire logic        head_valid_o,
  input wire logic signed [31:0] head_key_o,
  input wire logic [7:0]  head_tag_o,
  input wire logic [5:0]  count_o
);

  `SAPQ_ASSERT_NEXT(a_result_follows, start && !busy, result_valid_o)
  `SAPQ_ASSERT_NEXT(a_no_stray_result, !(start && !busy), !result_valid_o)
  `SAPQ_ASSERT_NOW(a_empty_head, result_valid_o && !head_valid_o,
                   head_key_o == sapq_pkg::EmptyKey && head_tag_o == sapq_pkg::EmptyTag)
  `SAPQ_ASSERT_NOW(a_head_matches_count, result_valid_o, head_valid_o == (count_o != 6'd0))
  `SAPQ_ASSERT_NOW(a_empty_deq_report, result_valid_o && status_o == sapq_pkg::ST_EMPTY,
                   out_key_o == sapq_pkg::EmptyKey && out_tag_o == sapq_pkg::EmptyTag)

endmodule

bind sorted_array_priority_queue_top sapq_checker u_sapq_checker (.*);

`default_nettype wire
